@@ design/nfa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared widths, codes and controller/datapath interface types for the NFA
// transition store with subset move and epsilon closure.
// ----------------------------------------------------------------------------
package nfa_pkg;

    // payload field widths
    localparam int OP_W    = 2;
    localparam int STATE_W = 5;
    localparam int SYM_W   = 4;
    localparam int SET_W   = 32;
    localparam int SYM_N   = 16;

    // configuration register widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int STATES_W   = 6;
    localparam int SYMBOLS_W  = 5;
    localparam int EPS_W      = 4;

    // widths that hold the limit values (up to 127 states, 511 symbols)
    localparam int STL_W = 7;
    localparam int SYL_W = 9;

    localparam logic [STATES_W-1:0]  STATES_RST  = 6'd32;
    localparam logic [SYMBOLS_W-1:0] SYMBOLS_RST = 5'd16;
    localparam logic [EPS_W-1:0]     EPS_RST     = 4'd0;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_CLR   = 2'd1,
        OP_MOVE  = 2'd2,
        OP_CLOSE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATES  = 2'd0,
        CFG_SYMBOLS = 2'd1,
        CFG_EPS     = 2'd2
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic edge_rd;
        logic edge_wr;
        logic scan;
        logic pass_start;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic err;
        logic is_edge;
        logic is_closure;
        logic idx_last;
        logic changed;
        logic out_free;
    } t_sts;

endpackage

@@ design/nfa_move_and_epsilon_closure_top.sv @@
// ----------------------------------------------------------------------------
// nfa_move_and_epsilon_closure_top
// NFA transition store with set/clear edge, symbol move and epsilon closure.
// ----------------------------------------------------------------------------
// After reset the block clears its transition table, one row per cycle, all
// 2**(clog2(min(NUM_STATES,32)) + clog2(min(NUM_SYMBOLS,16))) rows (512 at
// the defaults); input stall stays high during that sweep, configuration
// writes are taken throughout. Items are handled one at a time through a
// single-port-read table RAM, one row per cycle. Set and clear edge read the
// row and write it back modified; an item rejected by the range checks goes
// straight to the result. Symbol move scans all S = min(NUM_STATES,32) source
// rows once. Epsilon closure repeats that scan until a pass adds no state,
// with at most one pass more than the number of states added. A finished
// result waits in the output register, and the next item is accepted while
// it waits.
module nfa_move_and_epsilon_closure_top #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [nfa_pkg::OP_W-1:0]          i_opcode,
    input  logic [nfa_pkg::STATE_W-1:0]       i_from_state,
    input  logic [nfa_pkg::STATE_W-1:0]       i_to_state,
    input  logic [nfa_pkg::SYM_W-1:0]         i_symbol,
    input  logic [nfa_pkg::SET_W-1:0]         i_state_set,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [nfa_pkg::SET_W-1:0]         o_result_set,
    output logic                              o_status
);

    nfa_pkg::t_cmd cmd;
    nfa_pkg::t_sts sts;

    nfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    nfa_dp #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_opcode),
        .i_from_state (i_from_state),
        .i_to_state   (i_to_state),
        .i_symbol     (i_symbol),
        .i_state_set  (i_state_set),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_result_set (o_result_set),
        .o_status     (o_status)
    );

endmodule

@@ design/nfa_ram.sv @@
// ----------------------------------------------------------------------------
// nfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfa_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/nfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// nfa_ctrl
// Sequencer: table clearing sweep, edge read-modify-write, row scan passes
// for move and closure, and hand-off to the output register.
// ----------------------------------------------------------------------------
module nfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output nfa_pkg::t_cmd o_cmd,
    input  nfa_pkg::t_sts i_sts
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_START   = 8'b0000_0100,
        S_EDGE_WR = 8'b0000_1000,
        S_SCAN    = 8'b0001_0000,
        S_DRAIN   = 8'b0010_0000,
        S_CHECK   = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else if (i_sts.is_edge) begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_EDGE_WR;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_EDGE_WR: begin
                o_cmd.edge_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last row of the pass lands this cycle
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.is_closure && i_sts.changed) begin
                    o_cmd.pass_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ design/nfa_dp.sv @@
// ----------------------------------------------------------------------------
// nfa_dp
// Datapath: configuration registers, range checks, transition table RAM,
// row accumulator for move and closure, and the output register.
// ----------------------------------------------------------------------------
module nfa_dp #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nfa_pkg::t_cmd                     i_cmd,
    output nfa_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [nfa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [nfa_pkg::OP_W-1:0]          i_opcode,
    input  logic [nfa_pkg::STATE_W-1:0]       i_from_state,
    input  logic [nfa_pkg::STATE_W-1:0]       i_to_state,
    input  logic [nfa_pkg::SYM_W-1:0]         i_symbol,
    input  logic [nfa_pkg::SET_W-1:0]         i_state_set,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [nfa_pkg::SET_W-1:0]         o_result_set,
    output logic                              o_status
);

    // only states and symbols that the fields can name get table rows
    localparam int ST_N  = (NUM_STATES < nfa_pkg::SET_W) ? NUM_STATES : nfa_pkg::SET_W;
    localparam int SY_N  = (NUM_SYMBOLS < nfa_pkg::SYM_N) ? NUM_SYMBOLS : nfa_pkg::SYM_N;
    localparam int ST_W  = $clog2(ST_N);
    localparam int SY_W  = $clog2(SY_N);
    localparam int AW    = ST_W + SY_W;
    localparam int DEPTH = 1 << AW;

    localparam logic [nfa_pkg::STL_W-1:0] ST_LIM  = nfa_pkg::STL_W'(NUM_STATES);
    localparam logic [nfa_pkg::SYL_W-1:0] SY_LIM  = nfa_pkg::SYL_W'(NUM_SYMBOLS);
    localparam logic [ST_W-1:0]           IDX_END = ST_W'(ST_N - 1);

    // configuration
    logic [nfa_pkg::STATES_W-1:0]  r_states_in_use;
    logic [nfa_pkg::SYMBOLS_W-1:0] r_symbols_in_use;
    logic [nfa_pkg::EPS_W-1:0]     r_eps;

    // item registers
    nfa_pkg::t_op              r_op;
    logic [nfa_pkg::STATE_W-1:0] r_from;
    logic [nfa_pkg::STATE_W-1:0] r_to;
    logic [nfa_pkg::SYM_W-1:0]   r_sym;
    logic                        r_err;
    logic [ST_N-1:0]             r_set;
    logic [ST_N-1:0]             r_acc;
    logic [ST_N-1:0]             r_vmask;
    logic [ST_W-1:0]             r_idx;
    logic                        r_changed;

    // scan pipeline, clearing sweep, output
    logic            r_rd_vld;
    logic [ST_W-1:0] r_rd_idx;
    logic [AW-1:0]   r_clr_addr;
    logic            r_out_vld;
    logic [nfa_pkg::SET_W-1:0] r_out_set;
    logic            r_out_status;

    logic [nfa_pkg::STL_W-1:0] lim_states;
    logic [nfa_pkg::SYL_W-1:0] lim_symbols;
    logic [nfa_pkg::SET_W-1:0] vm_full;
    nfa_pkg::t_op              op_in;
    logic [nfa_pkg::SYM_W-1:0] sym_in;
    logic                      err_edge;
    logic                      err_query;
    logic                      err_in;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ST_N-1:0]     ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ST_N-1:0]     ram_rdata;
    logic [AW-1:0]       edge_addr;
    logic [ST_N-1:0]     to_bit;
    logic [ST_N-1:0]     row_mod;
    logic [ST_N-1:0]     acc_new;
    logic                member;
    logic                op_edge;

    // ---------------- limits and range checks ----------------
    always_comb begin
        lim_states  = ({1'b0, r_states_in_use} < ST_LIM) ? {1'b0, r_states_in_use} : ST_LIM;
        lim_symbols = ({4'b0, r_symbols_in_use} < SY_LIM) ? {4'b0, r_symbols_in_use} : SY_LIM;
        for (int i = 0; i < nfa_pkg::SET_W; i++) begin
            vm_full[i] = (nfa_pkg::STL_W'(i) < lim_states);
        end
        op_in     = nfa_pkg::t_op'(i_opcode);
        sym_in    = (op_in == nfa_pkg::OP_CLOSE) ? r_eps : i_symbol;
        err_edge  = ({2'b0, i_from_state} >= lim_states) ||
                    ({2'b0, i_to_state} >= lim_states) ||
                    ({5'b0, sym_in} >= lim_symbols);
        err_query = ({5'b0, sym_in} >= lim_symbols) ||
                    ((i_state_set & ~vm_full) != '0);
        err_in    = (op_in inside {nfa_pkg::OP_SET, nfa_pkg::OP_CLR}) ? err_edge : err_query;
    end

    // ---------------- table access ----------------
    assign op_edge   = (r_op inside {nfa_pkg::OP_SET, nfa_pkg::OP_CLR});
    assign edge_addr = {r_from[ST_W-1:0], r_sym[SY_W-1:0]};
    assign to_bit    = ST_N'(1) << r_to[ST_W-1:0];
    assign row_mod   = (r_op == nfa_pkg::OP_SET) ? (ram_rdata | to_bit) : (ram_rdata & ~to_bit);

    always_comb begin
        ram_we    = i_cmd.clr_wr | i_cmd.edge_wr;
        ram_waddr = i_cmd.clr_wr ? r_clr_addr : edge_addr;
        ram_wdata = i_cmd.clr_wr ? '0 : row_mod;
        ram_re    = i_cmd.edge_rd | i_cmd.scan;
        ram_raddr = i_cmd.edge_rd ? edge_addr : {r_idx, r_sym[SY_W-1:0]};
    end

    nfa_ram #(
        .W     (ST_N),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // move gathers rows of the fixed anchors; closure grows its own set
    assign member  = (r_op == nfa_pkg::OP_MOVE) ? r_set[r_rd_idx] : r_acc[r_rd_idx];
    assign acc_new = r_acc | (ram_rdata & r_vmask);

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states_in_use  <= nfa_pkg::STATES_RST;
            r_symbols_in_use <= nfa_pkg::SYMBOLS_RST;
            r_eps            <= nfa_pkg::EPS_RST;
            r_clr_addr       <= '0;
            r_rd_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (nfa_pkg::t_cfg_idx'(i_cfg_idx))
                    nfa_pkg::CFG_STATES:  r_states_in_use  <= i_cfg_data;
                    nfa_pkg::CFG_SYMBOLS: r_symbols_in_use <= i_cfg_data[nfa_pkg::SYMBOLS_W-1:0];
                    nfa_pkg::CFG_EPS:     r_eps            <= i_cfg_data[nfa_pkg::EPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (i_cmd.scan) begin
            r_idx <= r_idx + ST_W'(1);
        end
        if (r_rd_vld && member) begin
            r_acc <= acc_new;
            if (acc_new != r_acc) begin
                r_changed <= 1'b1;
            end
        end
        if (i_cmd.pass_start) begin
            r_idx     <= '0;
            r_changed <= 1'b0;
        end
        if (i_cmd.load) begin
            r_op      <= op_in;
            r_from    <= i_from_state;
            r_to      <= i_to_state;
            r_sym     <= sym_in;
            r_err     <= err_in;
            r_set     <= i_state_set[ST_N-1:0];
            r_acc     <= (op_in == nfa_pkg::OP_CLOSE) ? i_state_set[ST_N-1:0] : '0;
            r_vmask   <= vm_full[ST_N-1:0];
            r_idx     <= '0;
            r_changed <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_set    <= (r_err || op_edge) ? '0 : nfa_pkg::SET_W'(r_acc);
            r_out_status <= r_err;
        end
    end

    // ---------------- status ----------------
    always_comb begin
        o_sts.clr_last   = (r_clr_addr == '1);
        o_sts.err        = r_err;
        o_sts.is_edge    = op_edge;
        o_sts.is_closure = (r_op == nfa_pkg::OP_CLOSE);
        o_sts.idx_last   = (r_idx == IDX_END);
        o_sts.changed    = r_changed;
        o_sts.out_free   = !r_out_vld || !i_stall;
    end

    assign o_valid      = r_out_vld;
    assign o_result_set = r_out_set;
    assign o_status     = r_out_status;

endmodule

@@ design/nfa_chk.sv @@
// ----------------------------------------------------------------------------
// nfa_chk
// Port-level checks for the NFA move/closure block, bound to the top level.
// ----------------------------------------------------------------------------
module nfa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [nfa_pkg::SET_W-1:0]     o_result_set,
    input logic                          o_status
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_set) && $stable(o_status)))
        else $error("output beat changed while stalled");

    // an error result carries an empty set
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_result_set == '0))
        else $error("error result with nonzero set");

    // one item at a time: an accepted beat closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after an accept");

    // reset empties the output register and starts the table sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_stall))
        else $error("output valid or input open after reset");

endmodule

bind nfa_move_and_epsilon_closure_top nfa_chk u_nfa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_result_set (o_result_set),
    .o_status     (o_status)
);

@@ tb/tb_nfa_move_and_epsilon_closure_top.sv @@
// ----------------------------------------------------------------------------
// tb_nfa_move_and_epsilon_closure_top
// Self-checking bench for the NFA transition store. A table of directed beats
// covers field extremes, every opcode and the range errors. It is followed by
// phases of random beats under several register settings. Each result beat is
// checked against a fixed result or a model of the edge table and move/closure logic.
// ----------------------------------------------------------------------------
module tb_nfa_move_and_epsilon_closure_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W       = nfa_pkg::OP_W;
    localparam int STATE_W    = nfa_pkg::STATE_W;
    localparam int SYM_W      = nfa_pkg::SYM_W;
    localparam int SET_W      = nfa_pkg::SET_W;
    localparam int SYM_N      = nfa_pkg::SYM_N;
    localparam int CFG_IDX_W  = nfa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = nfa_pkg::CFG_DATA_W;
    localparam int STATES_W   = nfa_pkg::STATES_W;
    localparam int SYMBOLS_W  = nfa_pkg::SYMBOLS_W;
    localparam int EPS_W      = nfa_pkg::EPS_W;

    localparam int NUM_ST    = 32;
    localparam int LIMIT     = 4_000_000;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 75;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        nfa_pkg::t_op       op;
        logic [STATE_W-1:0] from_st;
        logic [STATE_W-1:0] to_st;
        logic [SYM_W-1:0]   sym;
        logic [SET_W-1:0]   anchors;
    } t_beat;

    typedef struct packed {
        logic [SET_W-1:0] reached;
        logic             status;
    } t_outcome;

    typedef struct {
        bit                   is_cfg;
        logic [STATES_W-1:0]  states;
        logic [SYMBOLS_W-1:0] symbols;
        logic [EPS_W-1:0]     eps;
        t_beat                beat;
        bit                   fixed;
        t_outcome             want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [OP_W-1:0]       i_opcode;
    logic [STATE_W-1:0]    i_from_state;
    logic [STATE_W-1:0]    i_to_state;
    logic [SYM_W-1:0]      i_symbol;
    logic [SET_W-1:0]      i_state_set;
    logic                  o_valid;
    logic                  i_stall;
    logic [SET_W-1:0]      o_result_set;
    logic                  o_status;

    nfa_move_and_epsilon_closure_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_from_state (i_from_state),
        .i_to_state   (i_to_state),
        .i_symbol     (i_symbol),
        .i_state_set  (i_state_set),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result_set (o_result_set),
        .o_status     (o_status)
    );

    // model state: edge table and register copies
    logic [SET_W-1:0]     edge_mem [NUM_ST][SYM_N];
    logic [STATES_W-1:0]  cfg_states;
    logic [SYMBOLS_W-1:0] cfg_symbols;
    logic [EPS_W-1:0]     cfg_eps;

    t_outcome reach_q [$];
    t_outcome want;
    t_row     dir_rows [$];
    int       err_cnt;
    int       cycle_cnt;
    int       burst_left;
    bit       hold_go;
    int       hold_left;
    int       rx_mode;
    int       rx_mode_left;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int state_lim();
        return (cfg_states < NUM_ST) ? int'(cfg_states) : NUM_ST;
    endfunction

    function automatic int symbol_lim();
        return (cfg_symbols < SYM_N) ? int'(cfg_symbols) : SYM_N;
    endfunction

    function automatic logic [SET_W-1:0] live_mask(int n);
        if (n >= SET_W)
            return '1;
        return (SET_W'(1) << n) - SET_W'(1);
    endfunction

    function automatic logic [SET_W-1:0] row_union(logic [SET_W-1:0] set, int sym, int n);
        logic [SET_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < n; i++)
            if (set[i])
                acc |= edge_mem[i][sym];
        return acc;
    endfunction

    // apply one beat to the model table and return its result
    function automatic t_outcome compute_reach(t_beat b);
        t_outcome         res;
        int               n;
        int               m;
        int               s;
        logic [SET_W-1:0] vm;
        logic [SET_W-1:0] cur;
        logic [SET_W-1:0] nxt;
        n   = state_lim();
        m   = symbol_lim();
        vm  = live_mask(n);
        res = '0;
        if (b.op == nfa_pkg::OP_SET || b.op == nfa_pkg::OP_CLR) begin
            if (b.from_st >= n || b.to_st >= n || b.sym >= m) begin
                res.status = 1'b1;
            end else if (b.op == nfa_pkg::OP_SET) begin
                edge_mem[b.from_st][b.sym][b.to_st] = 1'b1;
            end else begin
                edge_mem[b.from_st][b.sym][b.to_st] = 1'b0;
            end
        end else begin
            s = (b.op == nfa_pkg::OP_MOVE) ? int'(b.sym) : int'(cfg_eps);
            if (s >= m || (b.anchors & ~vm) != '0) begin
                res.status = 1'b1;
            end else if (b.op == nfa_pkg::OP_MOVE) begin
                res.reached = row_union(b.anchors, s, n) & vm;
            end else begin
                cur = b.anchors;
                while (1'b1) begin
                    nxt = (cur | row_union(cur, s, n)) & vm;
                    if (nxt == cur)
                        break;
                    cur = nxt;
                end
                res.reached = cur;
            end
        end
        return res;
    endfunction

    function automatic t_row item_row(nfa_pkg::t_op op, int from_st, int to_st, int sym,
                                      logic [SET_W-1:0] anchors, bit fixed,
                                      logic [SET_W-1:0] reached, logic status);
        t_row r;
        r              = '{default: '0};
        r.beat.op      = op;
        r.beat.from_st = STATE_W'(from_st);
        r.beat.to_st   = STATE_W'(to_st);
        r.beat.sym     = SYM_W'(sym);
        r.beat.anchors = anchors;
        r.fixed        = fixed;
        r.want.reached = reached;
        r.want.status  = status;
        return r;
    endfunction

    function automatic t_row cfg_row(int states, int symbols, int eps);
        t_row r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.states  = STATES_W'(states);
        r.symbols = SYMBOLS_W'(symbols);
        r.eps     = EPS_W'(eps);
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // mostly well-formed beats within the live limits, some raw noise
    function automatic t_beat make_beat();
        t_beat b;
        int    n;
        int    m;
        int    pick;
        n         = state_lim();
        m         = symbol_lim();
        b.op      = nfa_pkg::t_op'($urandom_range(0, 3));
        b.from_st = STATE_W'($urandom);
        b.to_st   = STATE_W'($urandom);
        b.sym     = SYM_W'($urandom);
        b.anchors = $urandom;
        if (n == 0 || m == 0 || $urandom_range(0, 99) < 10)
            return b;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            b.op = nfa_pkg::OP_SET;
        else if (pick < 50)
            b.op = nfa_pkg::OP_CLR;
        else if (pick < 75)
            b.op = nfa_pkg::OP_MOVE;
        else
            b.op = nfa_pkg::OP_CLOSE;
        b.from_st = STATE_W'($urandom_range(0, n - 1));
        b.to_st   = STATE_W'($urandom_range(0, n - 1));
        b.sym     = SYM_W'($urandom_range(0, m - 1));
        // favor epsilon edges so closures go several passes deep
        if (b.op == nfa_pkg::OP_SET && cfg_eps < m && $urandom_range(0, 2) == 0)
            b.sym = cfg_eps;
        case ($urandom_range(0, 2))
            0:       b.anchors = SET_W'(1) << $urandom_range(0, n - 1);
            1:       b.anchors = $urandom & $urandom & live_mask(n);
            default: b.anchors = $urandom & live_mask(n);
        endcase
        return b;
    endfunction

    // offer one beat, hold it until taken, then log its expected result
    task automatic offer_beat(t_beat b, bit fixed, t_outcome fixed_res);
        t_outcome res;
        i_valid      <= 1'b1;
        i_opcode     <= b.op;
        i_from_state <= b.from_st;
        i_to_state   <= b.to_st;
        i_symbol     <= b.sym;
        i_state_set  <= b.anchors;
        do
            @(posedge i_clk);
        while (o_stall);
        res = compute_reach(b);
        reach_q.insert(reach_q.size(), fixed ? fixed_res : res);
    endtask

    task automatic pace();
        int gap;
        if (burst_left != 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // drain every pending result, then write all three registers
    task automatic write_regs(logic [STATES_W-1:0] st, logic [SYMBOLS_W-1:0] sy,
                              logic [EPS_W-1:0] ep);
        i_valid <= 1'b0;
        while (reach_q.size() != 0)
            @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= nfa_pkg::CFG_STATES;
        i_cfg_data <= CFG_DATA_W'(st);
        @(posedge i_clk);
        cfg_states = st;
        i_cfg_idx  <= nfa_pkg::CFG_SYMBOLS;
        i_cfg_data <= CFG_DATA_W'(sy);
        @(posedge i_clk);
        cfg_symbols = sy;
        i_cfg_idx  <= nfa_pkg::CFG_EPS;
        i_cfg_data <= CFG_DATA_W'(ep);
        @(posedge i_clk);
        cfg_eps = ep;
        i_cfg_we <= 1'b0;
    endtask

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        i_stall      = 1'b0;
        hold_left    = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= 1'($urandom_range(0, 1));
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (reach_q.size() == 0) begin
                $error("unexpected result beat: result_set %h status %0d",
                       o_result_set, o_status);
                err_cnt++;
            end else begin
                want = reach_q.pop_front();
                if (o_result_set !== want.reached) begin
                    $error("result_set: expected %h, got %h", want.reached, o_result_set);
                    err_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_row r;
        err_cnt      = 0;
        cycle_cnt    = 0;
        burst_left   = 4;
        hold_go      = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = nfa_pkg::CFG_STATES;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_opcode     = nfa_pkg::OP_SET;
        i_from_state = '0;
        i_to_state   = '0;
        i_symbol     = '0;
        i_state_set  = '0;
        cfg_states   = nfa_pkg::STATES_RST;
        cfg_symbols  = nfa_pkg::SYMBOLS_RST;
        cfg_eps      = nfa_pkg::EPS_RST;
        for (int i = 0; i < NUM_ST; i++)
            for (int j = 0; j < SYM_N; j++)
                edge_mem[i][j] = '0;

        // empty table after reset: move finds nothing, closure returns the anchors
        add_row(item_row(nfa_pkg::OP_MOVE, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_CLOSE, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b0));
        add_row(item_row(nfa_pkg::OP_CLOSE, 0, 0, 0, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_SET, 31, 31, 15, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_SET, 0, 31, 0, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_SET, 31, 0, 0, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_SET, 5, 7, 3, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_MOVE, 0, 0, 3, 32'h0000_0020, 0, '0, 1'b0));
        add_row(item_row(nfa_pkg::OP_CLOSE, 0, 0, 0, 32'h0000_0001, 0, '0, 1'b0));
        add_row(item_row(nfa_pkg::OP_MOVE, 0, 0, 15, 32'h8000_0000, 0, '0, 1'b0));
        add_row(item_row(nfa_pkg::OP_CLR, 31, 31, 15, 32'h0, 1, 32'h0, 1'b0));
        // narrow limits: each range check on its own
        add_row(cfg_row(4, 2, 1));
        add_row(item_row(nfa_pkg::OP_SET, 4, 0, 0, 32'h0, 1, 32'h0, 1'b1));
        add_row(item_row(nfa_pkg::OP_SET, 0, 4, 0, 32'h0, 1, 32'h0, 1'b1));
        add_row(item_row(nfa_pkg::OP_CLR, 0, 0, 2, 32'h0, 1, 32'h0, 1'b1));
        add_row(item_row(nfa_pkg::OP_MOVE, 0, 0, 2, 32'h0000_0001, 1, 32'h0, 1'b1));
        add_row(item_row(nfa_pkg::OP_MOVE, 0, 0, 0, 32'h0000_0010, 1, 32'h0, 1'b1));
        add_row(item_row(nfa_pkg::OP_SET, 0, 1, 1, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_SET, 1, 3, 1, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_CLOSE, 0, 0, 0, 32'h0000_0001, 0, '0, 1'b0));
        // epsilon slot beyond the symbol limit
        add_row(cfg_row(4, 2, 15));
        add_row(item_row(nfa_pkg::OP_CLOSE, 0, 0, 0, 32'h0000_0001, 1, 32'h0, 1'b1));
        // zero limits reject everything
        add_row(cfg_row(0, 0, 0));
        add_row(item_row(nfa_pkg::OP_SET, 0, 0, 0, 32'h0, 1, 32'h0, 1'b1));
        add_row(item_row(nfa_pkg::OP_MOVE, 0, 0, 0, 32'h0, 1, 32'h0, 1'b1));
        add_row(item_row(nfa_pkg::OP_CLOSE, 0, 0, 0, 32'h0, 1, 32'h0, 1'b1));
        // register maxima clip to the table size
        add_row(cfg_row(63, 31, 15));
        add_row(item_row(nfa_pkg::OP_SET, 31, 30, 15, 32'h0, 1, 32'h0, 1'b0));
        add_row(item_row(nfa_pkg::OP_CLOSE, 0, 0, 0, 32'h8000_0000, 0, '0, 1'b0));
        add_row(item_row(nfa_pkg::OP_MOVE, 0, 0, 15, 32'hFFFF_FFFF, 0, '0, 1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.is_cfg) begin
                write_regs(r.states, r.symbols, r.eps);
            end else begin
                offer_beat(r.beat, r.fixed, r.want);
                pace();
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       write_regs(6'd32, 5'd16, 4'd0);
                1:       write_regs(6'd63, 5'd31, 4'd15);
                2:       write_regs(6'd1, 5'd1, 4'd0);
                3:       write_regs(6'd20, 5'd4, 4'd3);
                default: write_regs(STATES_W'($urandom_range(0, 63)),
                                    SYMBOLS_W'($urandom_range(0, 31)),
                                    EPS_W'($urandom_range(0, 15)));
            endcase
            // back up the block: receiver holds off while beats keep coming
            if (ph == 1)
                hold_go = 1'b1;
            for (int k = 0; k < PHASE_LEN; k++) begin
                offer_beat(make_beat(), 1'b0, '0);
                pace();
            end
        end

        i_valid <= 1'b0;
        while (reach_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ nfa_move_and_epsilon_closure_top.f @@
design/nfa_pkg.sv
design/nfa_ram.sv
design/nfa_ctrl.sv
design/nfa_dp.sv
design/nfa_move_and_epsilon_closure_top.sv
design/nfa_chk.sv
tb/tb_nfa_move_and_epsilon_closure_top.sv
